// ===== src/smt_pkg.sv =====
// ----------------------------------------------------------------------------
// smt_pkg: shared types for the sorted multiset table
// Operation and status codes, and the control word broadcast to every cell.
// ----------------------------------------------------------------------------
package smt_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_FIND   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_MISSING = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	localparam int unsigned KIND_BITS   = 2;
	localparam int unsigned STATUS_BITS = 2;
	localparam int unsigned IN_VAL_BITS = 32;

	// broadcast to all cells for the word being applied
	typedef struct packed {
		logic apply;  // a word is accepted this cycle
		op_t  kind;
		logic found;  // some cell holds the operand
		logic full;   // every cell holds a value
	} cell_ctl_t;

	// status flags a cell reports to its neighbors and the top level
	typedef struct packed {
		logic valid;  // cell holds a value
		logic lt;     // held value is below the operand
		logic hit;    // held value equals the operand
	} cell_stat_t;

endpackage

// ===== src/smt_if.sv =====
// ----------------------------------------------------------------------------
// smt_if: request and response channels of the sorted multiset table
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface smt_req_if
	import smt_pkg::*;
();
	logic                          valid;
	logic                          ready;
	logic [KIND_BITS-1:0]          kind;
	logic signed [IN_VAL_BITS-1:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

interface smt_rsp_if
	import smt_pkg::*;
#(
	parameter int unsigned CNT_BITS = 7
) ();
	logic                   valid;
	logic                   ready;
	logic [STATUS_BITS-1:0] status;
	logic [CNT_BITS-1:0]    count;

	modport source (output valid, output status, output count, input ready);
	modport sink   (input valid, input status, input count, output ready);
endinterface

// ===== src/smt_cell.sv =====
// ----------------------------------------------------------------------------
// smt_cell: one slot of the sorted table
// Holds one value; shifts right on insert, left on remove, from its neighbors.
// ----------------------------------------------------------------------------
module smt_cell
	import smt_pkg::*;
#(
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_ctl_t             ctl,
	input  logic [VALUE_BITS-1:0] opnd,
	input  logic [VALUE_BITS-1:0] prev_val,
	input  logic                  prev_valid,
	input  logic                  prev_lt,     // left neighbor below operand, or left end
	input  logic [VALUE_BITS-1:0] next_val,
	input  logic                  next_valid,
	output logic [VALUE_BITS-1:0] val,
	output cell_stat_t            stat
);

	logic [VALUE_BITS-1:0] val_q;
	logic                  valid_q;
	logic                  lt;
	logic                  shift_r;
	logic                  shift_l;

	assign lt = valid_q && ($signed(val_q) < $signed(opnd));

	assign stat.valid = valid_q;
	assign stat.lt    = lt;
	assign stat.hit   = valid_q && (val_q == opnd);
	assign val        = val_q;

	// cells at and after the lower bound move
	assign shift_r = ctl.apply && (ctl.kind == OP_INSERT) && !ctl.full && !lt;
	assign shift_l = ctl.apply && (ctl.kind == OP_REMOVE) && ctl.found && !lt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.apply && (ctl.kind == OP_CLEAR)) begin
			valid_q <= 1'b0;
		end else if (shift_r) begin
			valid_q <= prev_valid;
		end else if (shift_l) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_r) begin
			val_q <= prev_lt ? opnd : prev_val;
		end else if (shift_l) begin
			val_q <= next_val;
		end
	end

endmodule

// ===== src/sorted_multiset_table.sv =====
// ----------------------------------------------------------------------------
// sorted_multiset_table: ascending multiset of signed values in a cell chain
// Insert, remove, find and clear, one response word per request word.
// ----------------------------------------------------------------------------
//  channel | dir | fields                    | notes
//  req     | in  | kind[1:0], value[31:0]    | op code and signed operand
//  rsp     | out | status[1:0], count[6:0]   | one word per request word
//
//  One request word per cycle while req.ready is high; its response is
//  registered and shows in the cycle after acceptance. Every cell compares
//  and shifts in the same cycle, so the next word already sees the updated
//  table. Reset clears the fill count, the response valid flag and every
//  cell valid bit; cell data has none. A stalled response holds req.ready
//  low only while the output register is occupied and not being drained.
// ----------------------------------------------------------------------------
module sorted_multiset_table
	import smt_pkg::*;
#(
	parameter int unsigned CAPACITY   = 64,
	parameter int unsigned VALUE_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	smt_req_if.sink   req,
	smt_rsp_if.source rsp
);

	localparam int unsigned CNT_BITS = $clog2(CAPACITY + 1);

	logic                  accept;
	logic [VALUE_BITS-1:0] opnd;
	op_t                   kind;
	cell_ctl_t             ctl;
	logic [CNT_BITS-1:0]   fill_q;
	logic [CNT_BITS-1:0]   fill_nxt;
	logic                  full;
	logic                  found;
	status_t               status_nxt;
	logic                  rsp_valid_q;
	status_t               status_q;
	logic [CNT_BITS-1:0]   count_q;

	logic [VALUE_BITS-1:0] val_w   [CAPACITY];
	cell_stat_t            stat_w  [CAPACITY];
	logic [CAPACITY-1:0]   hit_vec;
	logic [CAPACITY-1:0]   valid_vec;

	// output register doubles as the skid stage
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign kind      = op_t'(req.kind);

	// operand: low VALUE_BITS bits, zero-filled when wider than the port
	if (VALUE_BITS <= IN_VAL_BITS) begin : g_opnd_trunc
		assign opnd = req.value[VALUE_BITS-1:0];
	end else begin : g_opnd_ext
		assign opnd = {{(VALUE_BITS - IN_VAL_BITS){1'b0}}, req.value};
	end

	assign full  = (fill_q == CNT_BITS'(CAPACITY));
	assign found = |hit_vec;  // a match anywhere sits at the lower bound

	assign ctl.apply = accept;
	assign ctl.kind  = kind;
	assign ctl.found = found;
	assign ctl.full  = full;

	// cell chain: left end sees an always-valid "smaller" neighbor,
	// right end sees an empty one
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_BITS-1:0] prev_val;
		logic                  prev_valid;
		logic                  prev_lt;
		logic [VALUE_BITS-1:0] next_val;
		logic                  next_valid;

		if (i == 0) begin : g_left
			assign prev_val   = '0;
			assign prev_valid = 1'b1;
			assign prev_lt    = 1'b1;
		end else begin : g_mid_l
			assign prev_val   = val_w[i-1];
			assign prev_valid = stat_w[i-1].valid;
			assign prev_lt    = stat_w[i-1].lt;
		end

		if (i == CAPACITY - 1) begin : g_right
			assign next_val   = '0;
			assign next_valid = 1'b0;
		end else begin : g_mid_r
			assign next_val   = val_w[i+1];
			assign next_valid = stat_w[i+1].valid;
		end

		smt_cell #(
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.opnd       (opnd),
			.prev_val   (prev_val),
			.prev_valid (prev_valid),
			.prev_lt    (prev_lt),
			.next_val   (next_val),
			.next_valid (next_valid),
			.val        (val_w[i]),
			.stat       (stat_w[i])
		);

		assign hit_vec[i]   = stat_w[i].hit;
		assign valid_vec[i] = stat_w[i].valid;
	end

	// next fill count and status for the accepted word
	always_comb begin
		fill_nxt   = fill_q;
		status_nxt = ST_DONE;
		unique case (kind)
			OP_INSERT: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					fill_nxt = fill_q + CNT_BITS'(1);
				end
			end
			OP_REMOVE: begin
				if (found) begin
					fill_nxt = fill_q - CNT_BITS'(1);
				end else begin
					status_nxt = ST_MISSING;
				end
			end
			OP_FIND: begin
				if (!found) begin
					status_nxt = ST_MISSING;
				end
			end
			OP_CLEAR: begin
				fill_nxt = '0;
			end
			default: begin
				fill_nxt = fill_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q      <= fill_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nxt;
			count_q  <= fill_nxt;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = status_q;
	assign rsp.count  = count_q;

`ifndef SYNTHESIS
	// occupied cells always match the fill count
	a_fill_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == fill_q)
		else $error("cell valid bits disagree with fill count");

	// occupied cells form one run from the left end
	a_cells_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec + CAPACITY'(1)) & valid_vec) == '0)
		else $error("cell valid bits not packed to the left");

	// an insert into a table with room grows it by one
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (kind == OP_INSERT) && !full |=>
			(rsp.count == $past(fill_q) + CNT_BITS'(1)) && (rsp.status == ST_DONE))
		else $error("insert did not grow the table");

	// a full status only comes from a full table
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (status_q == ST_FULL) |-> fill_q == CNT_BITS'(CAPACITY))
		else $error("full status with room left");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sorted multiset table
// A driver feeds request words in bursts from a queue of pending words,
// and a monitor drains responses under a changing stall pattern. A shadow
// sorted list predicts the status and count of every word, and the monitor
// checks each response against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import smt_pkg::*;

	localparam int unsigned CAPACITY   = 64;
	localparam int unsigned VALUE_BITS = 32;
	localparam int unsigned CNT_BITS   = 7;
	localparam int          RAND_WORDS = 1300;
	localparam int          IDLE_LIMIT = 5000;

	localparam logic signed [IN_VAL_BITS-1:0] VMAX = 32'sh7FFF_FFFF;
	localparam logic signed [IN_VAL_BITS-1:0] VMIN = 32'sh8000_0000;

	typedef struct {
		op_t                          op;
		logic signed [IN_VAL_BITS-1:0] operand;
		bit                           wait_idle;  // hold off until all answers are in
	} request_t;

	typedef struct {
		status_t             status;
		logic [CNT_BITS-1:0] count;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n;

	smt_req_if                          req_ch ();
	smt_rsp_if #(.CNT_BITS(CNT_BITS))   rsp_ch ();

	sorted_multiset_table #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	// shadow contents, kept in ascending order
	logic signed [IN_VAL_BITS-1:0] sorted_vals[$];
	answer_t  answers_due[$];
	request_t requests_todo[$];

	int fail_count = 0;
	int op_tally[4] = '{default: 0};
	int full_drops  = 0;
	int misses      = 0;
	int peak_fill   = 0;

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------
	function automatic int first_not_below(logic signed [IN_VAL_BITS-1:0] v);
		int i = 0;
		while (i < sorted_vals.size() && sorted_vals[i] < v)
			i++;
		return i;
	endfunction

	function automatic void predict_answer(op_t op, logic signed [IN_VAL_BITS-1:0] v);
		answer_t a;
		int      pos;
		a.status = ST_DONE;
		pos = first_not_below(v);
		case (op)
			OP_INSERT: begin
				if (sorted_vals.size() >= CAPACITY)
					a.status = ST_FULL;
				else
					sorted_vals.insert(pos, v);  // ahead of equal values already held
			end
			OP_REMOVE: begin
				if (pos < sorted_vals.size() && sorted_vals[pos] == v)
					sorted_vals.delete(pos);
				else
					a.status = ST_MISSING;
			end
			OP_FIND: begin
				if (!(pos < sorted_vals.size() && sorted_vals[pos] == v))
					a.status = ST_MISSING;
			end
			default: begin
				sorted_vals.delete();
			end
		endcase
		a.count = CNT_BITS'(sorted_vals.size());
		answers_due.push_back(a);
		op_tally[op]++;
		if (a.status == ST_FULL)
			full_drops++;
		if (a.status == ST_MISSING)
			misses++;
		if (sorted_vals.size() > peak_fill)
			peak_fill = sorted_vals.size();
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic void queue_word(op_t op, logic signed [IN_VAL_BITS-1:0] v,
			bit hold = 1'b0);
		request_t w;
		w.op        = op;
		w.operand   = v;
		w.wait_idle = hold;
		requests_todo.push_back(w);
	endfunction

	// mostly a narrow band so that duplicates, hits and removes are common
	function automatic logic signed [IN_VAL_BITS-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $signed($urandom_range(0, 20)) - 10;
		if (r < 80) begin
			case ($urandom_range(0, 5))
				0: return VMIN;
				1: return VMAX;
				2: return VMIN + 1;
				3: return VMAX - 1;
				4: return 0;
				default: return -1;
			endcase
		end
		return $urandom;
	endfunction

	function automatic op_t pick_op(int ins_pct, int rem_pct, int clr_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < ins_pct)
			return OP_INSERT;
		if (r < ins_pct + rem_pct)
			return OP_REMOVE;
		if (r < 100 - clr_pct)
			return OP_FIND;
		return OP_CLEAR;
	endfunction

	// ------------------------------------------------------------------
	// driver: bursts of words with random gaps
	// ------------------------------------------------------------------
	int       burst_left = 0;
	int       gap_left   = 0;
	request_t next_word;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.kind  <= OP_INSERT;
			req_ch.value <= '0;
			burst_left   = $urandom_range(1, 40);
			gap_left     = 0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				predict_answer(op_t'(req_ch.kind), req_ch.value);
			// a word still waiting for ready stays on the bus untouched
			if (!(req_ch.valid && !req_ch.ready)) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (requests_todo.size() == 0) begin
					req_ch.valid <= 1'b0;
				end else if (requests_todo[0].wait_idle && answers_due.size() != 0) begin
					req_ch.valid <= 1'b0;
				end else begin
					next_word = requests_todo.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.kind  <= next_word.op;
					req_ch.value <= next_word.operand;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: stall pattern on ready, check each response word
	// ------------------------------------------------------------------
	int         stall_mode = 0;
	int         mode_cycles = 0;
	logic [7:0] stall_pat = 8'hFF;
	answer_t    head;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_mode   = 0;
			mode_cycles  = 0;
			stall_pat    = 8'hFF;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (answers_due.size() == 0) begin
					$error("response word with nothing outstanding: status %0d count %0d",
						rsp_ch.status, rsp_ch.count);
					fail_count++;
				end else begin
					head = answers_due.pop_front();
					if (rsp_ch.status !== head.status) begin
						$error("status: expected %0d, got %0d", head.status, rsp_ch.status);
						fail_count++;
					end
					if (rsp_ch.count !== head.count) begin
						$error("count: expected %0d, got %0d", head.count, rsp_ch.count);
						fail_count++;
					end
				end
			end
			// switch between always ready, a rotating pattern and random draws ready three times in four
			mode_cycles++;
			if (mode_cycles >= 64) begin
				mode_cycles = 0;
				stall_mode  = $urandom_range(0, 2);
				stall_pat   = 8'($urandom) | 8'h01;
			end
			case (stall_mode)
				0: rsp_ch.ready <= 1'b1;
				1: begin
					rsp_ch.ready <= stall_pat[0];
					stall_pat = {stall_pat[0], stall_pat[7:1]};
				end
				default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// watchdog: cycles with no word moving on either channel
	// ------------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int rand_count;
		int seg_len;
		int mode;
		int i;

		arst_n = 1'b0;

		// directed: empty table, extremes, duplicates, misses, clear
		queue_word(OP_FIND,   0);
		queue_word(OP_REMOVE, 5);
		queue_word(OP_INSERT, VMAX);
		queue_word(OP_INSERT, VMIN);
		queue_word(OP_INSERT, 0);
		queue_word(OP_INSERT, -1);
		queue_word(OP_INSERT, 0);
		queue_word(OP_INSERT, 1);
		queue_word(OP_FIND,   VMIN);
		queue_word(OP_FIND,   VMAX);
		queue_word(OP_FIND,   2);
		queue_word(OP_FIND,   -2);
		queue_word(OP_REMOVE, 0);
		queue_word(OP_FIND,   0);
		queue_word(OP_REMOVE, 0);
		queue_word(OP_FIND,   0);
		queue_word(OP_REMOVE, VMAX);
		queue_word(OP_REMOVE, VMIN);
		queue_word(OP_CLEAR,  0, 1'b1);
		queue_word(OP_FIND,   -1);
		queue_word(OP_CLEAR,  VMAX);

		// fill past capacity so full drops show up early, after a full drain
		queue_word(OP_INSERT, pick_value(), 1'b1);
		for (i = 0; i < 72; i++)
			queue_word(OP_INSERT, pick_value());
		rand_count = 73;

		while (rand_count < RAND_WORDS) begin
			mode = $urandom_range(0, 3);
			case (mode)
				0: seg_len = $urandom_range(40, 90);
				1: seg_len = $urandom_range(20, 70);
				2: seg_len = $urandom_range(10, 50);
				default: seg_len = $urandom_range(5, 20);
			endcase
			for (i = 0; i < seg_len; i++) begin
				case (mode)
					0: queue_word(pick_op(85, 5, 0), pick_value(), $urandom_range(0, 199) == 0);
					1: queue_word(pick_op(10, 70, 0), pick_value(), $urandom_range(0, 199) == 0);
					2: queue_word(pick_op(34, 33, 3), pick_value(), $urandom_range(0, 199) == 0);
					default: queue_word(pick_op(25, 25, 25), $urandom);
				endcase
			end
			rand_count += seg_len;
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (requests_todo.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (answers_due.size() != 0)
			@(posedge clk);
		// leave room for any stray word
		repeat (10) @(posedge clk);

		$display("Run covered %0d insert, %0d remove, %0d find and %0d clear words.",
			op_tally[OP_INSERT], op_tally[OP_REMOVE], op_tally[OP_FIND], op_tally[OP_CLEAR]);
		$display("Saw %0d dropped inserts on a full table, %0d misses, peak count %0d.",
			full_drops, misses, peak_fill);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
src/smt_pkg.sv
src/smt_if.sv
src/smt_cell.sv
src/sorted_multiset_table.sv
bench/testbench.sv
